[design/bdd_pkg.sv]
// Shared types and constants for the block depuncture deinterleaver.
// Holds the register map, the configuration bundle and the result
// handoff struct. No dependencies.
package bdd_pkg;

  // configuration register map
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYMBOL_BITS   = 3'd0,
    REG_COLS          = 3'd1,
    REG_ROWS          = 3'd2,
    REG_PUNCT_COUNT   = 3'd3,
    REG_K_LEN         = 3'd4,
    REG_BLOCK_SYMBOLS = 3'd5
  } cfg_idx_t;

  // request function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  // register reset values
  localparam logic [3:0]  RST_SYMBOL_BITS   = 4'd4;
  localparam logic [7:0]  RST_COLS          = 8'd15;
  localparam logic [10:0] RST_ROWS          = 11'd1;
  localparam logic [7:0]  RST_PUNCT_COUNT   = 8'd0;
  localparam logic [7:0]  RST_K_LEN         = 8'd7;
  localparam logic [10:0] RST_BLOCK_SYMBOLS = 11'd15;

  typedef struct packed {
    logic [3:0]  symbol_bits;
    logic [7:0]  cols;
    logic [10:0] rows;
    logic [7:0]  punct_count;
    logic [7:0]  k_len;
    logic [10:0] block_symbols;
  } cfg_t;

  // result handoff from the controller to the output register
  typedef struct packed {
    logic load;
    logic error;
    logic last;
    logic zero;
  } res_t;

endpackage

[design/bdd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[design/bdd_ctrl.sv]
// Controller: bit packing, write pointer with puncture skipping, read
// pointer walk in deinterleaved order, and the request state machine.
// Depends on bdd_pkg; drives the frame RAM ports.
module bdd_ctrl
  import bdd_pkg::*;
#(
  parameter int MAX_SYMBOLS  = 1024,
  parameter int SYMBOL_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           in_valid,
  input  logic                           in_func,
  input  logic                           in_bit_in,
  output logic                           in_ready,
  input  logic                           out_free,
  output logic                           mem_we,
  output logic [$clog2(MAX_SYMBOLS)-1:0] mem_waddr,
  output logic [SYMBOL_WIDTH-1:0]        mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(MAX_SYMBOLS)-1:0] mem_raddr,
  output res_t                           res
);

  localparam int AW   = $clog2(MAX_SYMBOLS);
  localparam int PW   = $clog2(MAX_SYMBOLS + 256);
  localparam int CW   = $clog2(SYMBOL_WIDTH + 1);
  localparam int RAW  = $clog2(256 * 2048 + MAX_SYMBOLS + 256);
  localparam int SW   = SYMBOL_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_SKIP, S_READ} state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   bit_shift_r, bit_shift_nxt;
  logic [CW-1:0]   bit_count_r, bit_count_nxt;
  logic [SW-1:0]   sym_r, sym_nxt;
  logic [PW-1:0]   wr_pos_r, wr_pos_nxt;
  logic [10:0]     wr_row_r, wr_row_nxt;
  logic [PW-1:0]   wr_col_r, wr_col_nxt;
  logic [PW-1:0]   rcvd_r, rcvd_nxt;
  logic [PW-1:0]   rd_count_r, rd_count_nxt;
  logic [PW-1:0]   rd_row_r, rd_row_nxt;
  logic [7:0]      rd_col_r, rd_col_nxt;
  logic [10:0]     rd_rem_r, rd_rem_nxt;
  logic [PW-1:0]   rd_quot_r, rd_quot_nxt;
  logic [RAW-1:0]  rd_addr_r, rd_addr_nxt;
  logic            frame_ready_r, frame_ready_nxt;
  logic            pend_zero_r, pend_zero_nxt;
  logic            pend_last_r, pend_last_nxt;

  // effective configuration
  logic [CW-1:0]   nb;
  logic [10:0]     erows;
  logic [7:0]      ecols;
  logic [PW-1:0]   eblock;
  logic            punct_on;
  logic [PW-1:0]   frame_len;
  logic [SW-1:0]   mask;
  logic [SW:0]     shift_ext;
  logic [SW-1:0]   shifted;
  logic            sym_done;
  logic            wr_punct;
  logic [PW+1:0]   rd_scol;
  logic            rd_punct;
  logic            rd_zero;
  logic            rd_last;
  logic            accept;
  logic            do_adv;
  logic            do_commit;
  logic [SW-1:0]   commit_data;
  logic            clear_all;

  always_comb begin
    if (cfg.symbol_bits == 4'd0) begin
      nb = CW'(1);
    end else if (int'(cfg.symbol_bits) > SYMBOL_WIDTH) begin
      nb = CW'(SYMBOL_WIDTH);
    end else begin
      nb = CW'(cfg.symbol_bits);
    end
    erows = (cfg.rows == 11'd0) ? 11'd1 : cfg.rows;
    ecols = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
    if (cfg.block_symbols == 11'd0) begin
      eblock = PW'(1);
    end else if (int'(cfg.block_symbols) > MAX_SYMBOLS) begin
      eblock = PW'(MAX_SYMBOLS);
    end else begin
      eblock = PW'(cfg.block_symbols);
    end
    punct_on  = cfg.punct_count < cfg.k_len;
    frame_len = eblock + (punct_on ? PW'(cfg.punct_count) : PW'(0));
    for (int i = 0; i < SW; i++) begin
      mask[i] = (i < int'(nb));
    end
  end

  assign shift_ext = {bit_shift_r, in_bit_in};
  assign shifted   = shift_ext[SW-1:0] & mask;
  assign sym_done  = ((CW+1)'(bit_count_r) + (CW+1)'(1)) >= (CW+1)'(nb);

  // stored position closes one of the last punct_count columns
  assign wr_punct = punct_on && (wr_row_r == erows - 11'd1) &&
                    (wr_col_r < PW'(ecols)) &&
                    ((PW+1)'(wr_col_r) + (PW+1)'(cfg.punct_count) >= (PW+1)'(ecols));

  // stored column of the read position: read column plus row overflow
  assign rd_scol  = (PW+2)'(rd_col_r) + (PW+2)'(rd_quot_r);
  assign rd_punct = punct_on && (rd_rem_r == erows - 11'd1) &&
                    (rd_scol < (PW+2)'(ecols)) &&
                    (rd_scol + (PW+2)'(cfg.punct_count) >= (PW+2)'(ecols));
  assign rd_zero  = (rd_addr_r >= RAW'(frame_len)) ||
                    (rd_addr_r >= RAW'(MAX_SYMBOLS)) || rd_punct;
  assign rd_last  = ((PW+1)'(rd_count_r) + (PW+1)'(1)) >= (PW+1)'(frame_len);

  assign in_ready = (state_r == S_IDLE) && ((in_func == FUNC_PUSH) || out_free);
  assign accept   = in_valid && in_ready;

  assign mem_waddr = wr_pos_r[AW-1:0];
  assign mem_wdata = commit_data;
  assign mem_raddr = rd_addr_r[AW-1:0];

  always_comb begin
    state_nxt       = state_r;
    bit_shift_nxt   = bit_shift_r;
    bit_count_nxt   = bit_count_r;
    sym_nxt         = sym_r;
    wr_pos_nxt      = wr_pos_r;
    wr_row_nxt      = wr_row_r;
    wr_col_nxt      = wr_col_r;
    rcvd_nxt        = rcvd_r;
    rd_count_nxt    = rd_count_r;
    rd_row_nxt      = rd_row_r;
    rd_col_nxt      = rd_col_r;
    rd_rem_nxt      = rd_rem_r;
    rd_quot_nxt     = rd_quot_r;
    rd_addr_nxt     = rd_addr_r;
    frame_ready_nxt = frame_ready_r;
    pend_zero_nxt   = pend_zero_r;
    pend_last_nxt   = pend_last_r;
    do_adv          = 1'b0;
    do_commit       = 1'b0;
    commit_data     = sym_r;
    clear_all       = 1'b0;
    mem_re          = 1'b0;
    res             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_func == FUNC_PUSH && !frame_ready_r) begin
          if (sym_done) begin
            bit_shift_nxt = '0;
            bit_count_nxt = '0;
            sym_nxt       = shifted;
            commit_data   = shifted;
            if (wr_punct) begin
              // skip punctured slots before storing
              do_adv    = 1'b1;
              state_nxt = S_SKIP;
            end else begin
              do_commit = 1'b1;
            end
          end else begin
            bit_shift_nxt = shifted;
            bit_count_nxt = bit_count_r + CW'(1);
          end
        end else if (accept && in_func == FUNC_PULL) begin
          if (!frame_ready_r) begin
            res.load  = 1'b1;
            res.error = 1'b1;
          end else begin
            mem_re        = 1'b1;
            pend_zero_nxt = rd_zero;
            pend_last_nxt = rd_last;
            state_nxt     = S_READ;
            if (rd_last) begin
              clear_all = 1'b1;
            end else begin
              rd_count_nxt = rd_count_r + PW'(1);
              if ((9'(rd_col_r) + 9'd1) >= 9'(ecols)) begin
                rd_col_nxt = '0;
                rd_row_nxt = rd_row_r + PW'(1);
                rd_addr_nxt = RAW'(rd_row_nxt);
                if ((rd_rem_r + 11'd1) >= erows) begin
                  rd_rem_nxt  = '0;
                  rd_quot_nxt = rd_quot_r + PW'(1);
                end else begin
                  rd_rem_nxt = rd_rem_r + 11'd1;
                end
              end else begin
                rd_col_nxt  = rd_col_r + 8'd1;
                rd_addr_nxt = rd_addr_r + RAW'(erows);
              end
            end
          end
        end
      end
      S_SKIP: begin
        if (wr_punct) begin
          do_adv = 1'b1;
        end else begin
          do_commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        res.load  = 1'b1;
        res.last  = pend_last_r;
        res.zero  = pend_zero_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_commit) begin
      do_adv   = 1'b1;
      rcvd_nxt = rcvd_r + PW'(1);
      if ((rcvd_r + PW'(1)) >= eblock) begin
        frame_ready_nxt = 1'b1;
        rd_count_nxt    = '0;
        rd_row_nxt      = '0;
        rd_col_nxt      = '0;
        rd_rem_nxt      = '0;
        rd_quot_nxt     = '0;
        rd_addr_nxt     = '0;
      end
    end

    if (do_adv) begin
      wr_pos_nxt = wr_pos_r + PW'(1);
      if ((wr_row_r + 11'd1) >= erows) begin
        wr_row_nxt = '0;
        wr_col_nxt = wr_col_r + PW'(1);
      end else begin
        wr_row_nxt = wr_row_r + 11'd1;
      end
    end

    if (clear_all) begin
      bit_shift_nxt   = '0;
      bit_count_nxt   = '0;
      wr_pos_nxt      = '0;
      wr_row_nxt      = '0;
      wr_col_nxt      = '0;
      rcvd_nxt        = '0;
      rd_count_nxt    = '0;
      rd_row_nxt      = '0;
      rd_col_nxt      = '0;
      rd_rem_nxt      = '0;
      rd_quot_nxt     = '0;
      rd_addr_nxt     = '0;
      frame_ready_nxt = 1'b0;
    end
  end

  // drop writes past the end of the store
  assign mem_we = do_commit && (wr_pos_r < PW'(MAX_SYMBOLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bit_shift_r   <= '0;
      bit_count_r   <= '0;
      wr_pos_r      <= '0;
      wr_row_r      <= '0;
      wr_col_r      <= '0;
      rcvd_r        <= '0;
      rd_count_r    <= '0;
      rd_row_r      <= '0;
      rd_col_r      <= '0;
      rd_rem_r      <= '0;
      rd_quot_r     <= '0;
      rd_addr_r     <= '0;
      frame_ready_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      bit_shift_r   <= bit_shift_nxt;
      bit_count_r   <= bit_count_nxt;
      wr_pos_r      <= wr_pos_nxt;
      wr_row_r      <= wr_row_nxt;
      wr_col_r      <= wr_col_nxt;
      rcvd_r        <= rcvd_nxt;
      rd_count_r    <= rd_count_nxt;
      rd_row_r      <= rd_row_nxt;
      rd_col_r      <= rd_col_nxt;
      rd_rem_r      <= rd_rem_nxt;
      rd_quot_r     <= rd_quot_nxt;
      rd_addr_r     <= rd_addr_nxt;
      frame_ready_r <= frame_ready_nxt;
    end
    sym_r       <= sym_nxt;
    pend_zero_r <= pend_zero_nxt;
    pend_last_r <= pend_last_nxt;
  end

endmodule

[design/block_depuncture_deinterleaver.sv]
// Top level of the block depuncture deinterleaver.
// Holds the configuration registers and the output register; instantiates
// bdd_ctrl and bdd_ram. Depends on bdd_pkg.
// Usage:
//  - Input channel (in_valid/in_ready): each request carries in_func.
//    A push request (func 0) shifts in_bit_in MSB first into a symbol of
//    symbol_bits bits; a completed symbol goes to the next frame slot,
//    skipping punctured slots. A pull request (func 1) returns one
//    deinterleaved symbol, or error when no complete frame is loaded.
//  - Output channel (out_valid/out_ready): one result per pull request,
//    held in a single output register until taken.
//  - Config port: cfg_we writes cfg_wdata into register cfg_index at once;
//    write only while no request is in flight.
// Timing: while a completed symbol skips punctured slots, no new request is
// taken. A pull reads the frame RAM, then loads the output register; a pull
// with no frame loaded skips the RAM read and loads its error result.
// Pushes are taken while a result waits; a pull waits for the output
// register to be free, so a stalled receiver holds off pulls only.
// Reset: counters clear, the block enters the loading phase, config
// registers take their reset values; frame RAM contents are not cleared.
module block_depuncture_deinterleaver
  import bdd_pkg::*;
#(
  parameter int MAX_SYMBOLS  = 1024,
  parameter int SYMBOL_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic                in_bit_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_symbol,
  output logic                out_last,
  output logic                out_error,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_SYMBOLS);

  cfg_t                    cfg_r;
  res_t                    res;
  logic                    out_valid_r;
  logic [7:0]              out_symbol_r;
  logic                    out_last_r;
  logic                    out_error_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [SYMBOL_WIDTH-1:0] mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [SYMBOL_WIDTH-1:0] mem_rdata;
  logic [SYMBOL_WIDTH+7:0] rdata_ext;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_bits   <= RST_SYMBOL_BITS;
      cfg_r.cols          <= RST_COLS;
      cfg_r.rows          <= RST_ROWS;
      cfg_r.punct_count   <= RST_PUNCT_COUNT;
      cfg_r.k_len         <= RST_K_LEN;
      cfg_r.block_symbols <= RST_BLOCK_SYMBOLS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMBOL_BITS:   cfg_r.symbol_bits   <= cfg_wdata[3:0];
        REG_COLS:          cfg_r.cols          <= cfg_wdata[7:0];
        REG_ROWS:          cfg_r.rows          <= cfg_wdata[10:0];
        REG_PUNCT_COUNT:   cfg_r.punct_count   <= cfg_wdata[7:0];
        REG_K_LEN:         cfg_r.k_len         <= cfg_wdata[7:0];
        REG_BLOCK_SYMBOLS: cfg_r.block_symbols <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  bdd_ctrl #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_bit_in (in_bit_in),
    .in_ready  (in_ready),
    .out_free  (!out_valid_r || out_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  bdd_ram #(
    .WIDTH (SYMBOL_WIDTH),
    .DEPTH (MAX_SYMBOLS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // zero-extend, then keep the low 8 bits of the stored symbol
  assign rdata_ext = {8'd0, mem_rdata};

  // output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res.load) begin
      out_symbol_r <= (res.error || res.zero) ? 8'd0 : rdata_ext[7:0];
      out_last_r   <= res.last;
      out_error_r  <= res.error;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_error  = out_error_r;

endmodule
